[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the pulse width code receiver.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is high.
`define RFPWC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent assertion that is checked during reset as well.
`define RFPWC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/rfpwc_pkg.sv]
// Types, constants and register indexes of the pulse width code receiver.
// No dependencies.
package rfpwc_pkg;

   localparam int WIDTH_W = 16;
   localparam int CODE_W = 24;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int FRAME_BITS_DEFAULT = 25;

   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_MIN = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SYNC_MAX = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_MIN = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_ZERO_MAX = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_MIN = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_MAX = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] REG_PAIRED_ID = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] REG_PAIRED_MODE = 3'd7;

   localparam logic [WIDTH_W-1:0] SYNC_MIN_RESET = 16'd5500;
   localparam logic [WIDTH_W-1:0] SYNC_MAX_RESET = 16'd10000;
   localparam logic [WIDTH_W-1:0] ZERO_MIN_RESET = 16'd100;
   localparam logic [WIDTH_W-1:0] ZERO_MAX_RESET = 16'd400;
   localparam logic [WIDTH_W-1:0] ONE_MIN_RESET = 16'd400;
   localparam logic [WIDTH_W-1:0] ONE_MAX_RESET = 16'd900;
   localparam logic [CODE_W-1:0] PAIRED_ID_RESET = 24'h000000;

   typedef struct packed {
      logic [WIDTH_W-1:0] sync_floor_us;
      logic [WIDTH_W-1:0] sync_ceil_us;
      logic [WIDTH_W-1:0] zero_min_us;
      logic [WIDTH_W-1:0] zero_max_us;
      logic [WIDTH_W-1:0] one_min_us;
      logic [WIDTH_W-1:0] one_max_us;
      logic [CODE_W-1:0] paired_id;
      logic paired_mode;
   } cfg_type;

   // True when the value lies strictly between the two bounds.
   function automatic logic in_window(logic [WIDTH_W-1:0] value,
                                      logic [WIDTH_W-1:0] lo,
                                      logic [WIDTH_W-1:0] hi);
      return (value > lo) && (value < hi);
   endfunction

endpackage

[hdl/rfpwc_if.sv]
// Valid/ready channel interfaces for edge items and decoded frame items.
// Depends on rfpwc_pkg.
interface rfpwc_req_if;
   import rfpwc_pkg::*;
   logic valid;
   logic ready;
   logic rising_edge;
   logic [WIDTH_W-1:0] width_us;
   modport source (output valid, output rising_edge, output width_us, input ready);
   modport sink (input valid, input rising_edge, input width_us, output ready);
endinterface

interface rfpwc_rsp_if;
   import rfpwc_pkg::*;
   logic valid;
   logic ready;
   logic [CODE_W-1:0] frame_code;
   logic id_match;
   logic pair_candidate;
   modport source (output valid, output frame_code, output id_match,
                   output pair_candidate, input ready);
   modport sink (input valid, input frame_code, input id_match,
                 input pair_candidate, output ready);
endinterface

[hdl/rfpwc_csr.sv]
// Configuration register file of the pulse width code receiver.
// Depends on rfpwc_pkg.
module rfpwc_csr (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [rfpwc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rfpwc_pkg::CSR_DATA_W-1:0] csr_wdata,
   output rfpwc_pkg::cfg_type cfg
);
   import rfpwc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_SYNC_MIN: cfg_in.sync_floor_us = csr_wdata[WIDTH_W-1:0];
            REG_SYNC_MAX: cfg_in.sync_ceil_us = csr_wdata[WIDTH_W-1:0];
            REG_ZERO_MIN: cfg_in.zero_min_us = csr_wdata[WIDTH_W-1:0];
            REG_ZERO_MAX: cfg_in.zero_max_us = csr_wdata[WIDTH_W-1:0];
            REG_ONE_MIN: cfg_in.one_min_us = csr_wdata[WIDTH_W-1:0];
            REG_ONE_MAX: cfg_in.one_max_us = csr_wdata[WIDTH_W-1:0];
            REG_PAIRED_ID: cfg_in.paired_id = csr_wdata[CODE_W-1:0];
            REG_PAIRED_MODE: cfg_in.paired_mode = csr_wdata[0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_floor_us <= SYNC_MIN_RESET;
         cfg_ff.sync_ceil_us <= SYNC_MAX_RESET;
         cfg_ff.zero_min_us <= ZERO_MIN_RESET;
         cfg_ff.zero_max_us <= ZERO_MAX_RESET;
         cfg_ff.one_min_us <= ONE_MIN_RESET;
         cfg_ff.one_max_us <= ONE_MAX_RESET;
         cfg_ff.paired_id <= PAIRED_ID_RESET;
         cfg_ff.paired_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/rfpwc_core.sv]
// Edge register, window decode, frame shifter and result register.
// Depends on rfpwc_pkg.
module rfpwc_core #(
   parameter int FRAME_BITS = rfpwc_pkg::FRAME_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  rfpwc_pkg::cfg_type cfg,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_rising_edge,
   input  logic [rfpwc_pkg::WIDTH_W-1:0] req_width_us,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [rfpwc_pkg::CODE_W-1:0] rsp_frame_code,
   output logic rsp_id_match,
   output logic rsp_pair_candidate
);
   import rfpwc_pkg::*;

   localparam int CNT_W = $clog2(FRAME_BITS + 1);

   logic in_valid_ff, in_valid_in;
   logic in_rise_ff;
   logic [WIDTH_W-1:0] in_width_ff;

   logic armed_ff, armed_in;
   logic [CODE_W-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [CODE_W-1:0] rsp_code_ff, rsp_code_in;
   logic rsp_match_ff, rsp_match_in;
   logic rsp_cand_ff, rsp_cand_in;

   logic advance, fire, take_in;
   logic sync_hit, zero_hit, one_hit;
   logic [CODE_W-1:0] shift_next;
   logic [CNT_W-1:0] count_next;
   logic frame_done;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;
   assign take_in = req_valid && req_ready;
   assign in_valid_in = take_in || (in_valid_ff && !advance);

   assign sync_hit = in_window(in_width_ff, cfg.sync_floor_us, cfg.sync_ceil_us);
   assign zero_hit = in_window(in_width_ff, cfg.zero_min_us, cfg.zero_max_us);
   assign one_hit = in_window(in_width_ff, cfg.one_min_us, cfg.one_max_us);

   assign shift_next = {shift_ff[CODE_W-2:0], !zero_hit};
   assign count_next = CNT_W'(count_ff + 1'b1);
   assign frame_done = (count_next == CNT_W'(FRAME_BITS));

   always_comb begin
      armed_in = armed_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_code_in = rsp_code_ff;
      rsp_match_in = rsp_match_ff;
      rsp_cand_in = rsp_cand_ff;
      if (fire) begin
         if (in_rise_ff) begin
            if (!armed_ff && sync_hit) begin
               armed_in = 1'b1;
            end
         end else if (armed_ff && (zero_hit || one_hit)) begin
            shift_in = shift_next;
            count_in = count_next;
            if (frame_done) begin
               rsp_valid_in = 1'b1;
               rsp_code_in = shift_next;
               rsp_match_in = cfg.paired_mode && (shift_next == cfg.paired_id)
                              && (shift_next != '0);
               rsp_cand_in = !cfg.paired_mode;
               if (cfg.paired_mode) begin
                  shift_in = '0;
               end
               count_in = '0;
               armed_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         armed_ff <= 1'b0;
         shift_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         armed_ff <= armed_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (take_in) begin
         in_rise_ff <= req_rising_edge;
         in_width_ff <= req_width_us;
      end
      rsp_code_ff <= rsp_code_in;
      rsp_match_ff <= rsp_match_in;
      rsp_cand_ff <= rsp_cand_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_code = rsp_code_ff;
   assign rsp_id_match = rsp_match_ff;
   assign rsp_pair_candidate = rsp_cand_ff;

endmodule

[hdl/rf_pulse_width_code_receiver.sv]
// Top level of the pulse width code receiver: decodes remote control frames
// from edge timing items. Depends on rfpwc_pkg, rfpwc_if, rfpwc_csr, rfpwc_core.
//
// Usage:
// The req channel carries one item per signal edge: rising_edge and the
// width_us since the previous edge. A low period inside the sync window arms
// the receiver; each high period inside the zero or one window then adds a
// bit. After FRAME_BITS bits one item leaves on the rsp channel with the low
// 24 bits of the code, id_match and pair_candidate.
// The csr port writes the timing windows, the paired identity and the mode;
// write it only while no item is in flight.
// An accepted edge is held in the edge register, and its result in the result
// register. One edge is accepted every cycle while rsp does not stall, set by
// the single decode stage between the two registers.
// When the rsp side stalls, the result is held and one more edge is taken
// into the edge register; req_ready then drops until the result is taken.
// Reset is synchronous: it disarms the receiver, clears the bit count and the
// code register, drops both valid flags and loads the default windows.
module rf_pulse_width_code_receiver #(
   parameter int FRAME_BITS = rfpwc_pkg::FRAME_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   rfpwc_req_if.sink req_chan,
   rfpwc_rsp_if.source rsp_chan,
   input  logic csr_we,
   input  logic [rfpwc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rfpwc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rfpwc_pkg::*;

   cfg_type cfg;

   rfpwc_csr u_csr (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cfg(cfg)
   );

   rfpwc_core #(
      .FRAME_BITS(FRAME_BITS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .cfg(cfg),
      .req_valid(req_chan.valid),
      .req_ready(req_chan.ready),
      .req_rising_edge(req_chan.rising_edge),
      .req_width_us(req_chan.width_us),
      .rsp_valid(rsp_chan.valid),
      .rsp_ready(rsp_chan.ready),
      .rsp_frame_code(rsp_chan.frame_code),
      .rsp_id_match(rsp_chan.id_match),
      .rsp_pair_candidate(rsp_chan.pair_candidate)
   );

endmodule

[hdl/rfpwc_checker.sv]
// Port level checks of the pulse width code receiver, bound to the top level.
// Depends on rfpwc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rfpwc_checker (
   input  logic clock,
   input  logic reset,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [rfpwc_pkg::CODE_W-1:0] rsp_frame_code,
   input  logic rsp_id_match,
   input  logic rsp_pair_candidate
);
   import rfpwc_pkg::*;

   `RFPWC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_code), "Stalled rsp item changed or vanished.")
   `RFPWC_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "Result item present right after reset.")
   `RFPWC_ASSERT(a_flags_exclusive, clock, reset, rsp_valid |-> !(rsp_id_match && rsp_pair_candidate), "An item is both an identity match and a pairing candidate.")
   `RFPWC_ASSERT(a_match_nonzero, clock, reset, rsp_valid && rsp_id_match |-> rsp_frame_code != '0, "Identity match reported for an all-zero code.")

endmodule

bind rf_pulse_width_code_receiver rfpwc_checker u_checker (
   .clock(clock),
   .reset(reset),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_frame_code(rsp_chan.frame_code),
   .rsp_id_match(rsp_chan.id_match),
   .rsp_pair_candidate(rsp_chan.pair_candidate)
);

[tb/rf_pulse_width_code_receiver_test.sv]
// Self-checking testbench of the pulse width code receiver: edge items go in
// through a queue-fed driver, decoded frames are checked against a local decoder.
// Depends on rfpwc_pkg, rfpwc_if and rf_pulse_width_code_receiver.
`timescale 1ns / 100ps

module rf_pulse_width_code_receiver_test;
   import rfpwc_pkg::*;

   localparam int FRAME_BITS = FRAME_BITS_DEFAULT;
   localparam int ITEM_TARGET = 1600;
   localparam int FRAME_TARGET = 30;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int DRAIN_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 6;

   typedef struct {
      logic rising_edge;
      logic [WIDTH_W-1:0] width_us;
   } edge_item_type;

   typedef struct {
      logic [CODE_W-1:0] frame_code;
      logic id_match;
      logic pair_candidate;
   } frame_item_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rfpwc_req_if req_bus();
   rfpwc_rsp_if rsp_bus();

   rf_pulse_width_code_receiver #(
      .FRAME_BITS(FRAME_BITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   edge_item_type pending_edges[$];
   frame_item_type expected_frames[$];
   frame_item_type oldest_frame;

   cfg_type rx_cfg;
   logic rx_armed;
   logic [CODE_W-1:0] rx_shift;
   logic [4:0] rx_count;

   bit sender_calm;
   bit receiver_calm;
   bit hold_off_request;
   int send_wait_left;
   int rsp_wait_left;
   int rsp_draw;
   int error_count;
   int edges_pushed;
   int edges_accepted;
   int frames_pushed;
   int frames_checked;
   int setting_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("rf_pulse_width_code_receiver_test: errors");
      $finish;
   end

   function automatic int draw_wait(input bit calm);
      if (calm || $urandom_range(0, 4) == 0) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic void decode_edge(input logic rising, input logic [WIDTH_W-1:0] w);
      logic bit_value;
      frame_item_type frame;
      if (rising) begin
         if (!rx_armed && w > rx_cfg.sync_floor_us && w < rx_cfg.sync_ceil_us) rx_armed = 1'b1;
         return;
      end
      if (!rx_armed) return;
      if (w > rx_cfg.zero_min_us && w < rx_cfg.zero_max_us) bit_value = 1'b0;
      else if (w > rx_cfg.one_min_us && w < rx_cfg.one_max_us) bit_value = 1'b1;
      else return;
      rx_shift = {rx_shift[CODE_W-2:0], bit_value};
      rx_count = rx_count + 5'd1;
      if (rx_count < FRAME_BITS) return;
      frame.frame_code = rx_shift;
      frame.id_match = rx_cfg.paired_mode && rx_shift == rx_cfg.paired_id && rx_shift != '0;
      frame.pair_candidate = !rx_cfg.paired_mode;
      expected_frames.push_back(frame);
      if (rx_cfg.paired_mode) rx_shift = '0;
      rx_count = '0;
      rx_armed = 1'b0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_wait_left <= 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_edge(req_bus.rising_edge, req_bus.width_us);
            edges_accepted++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_wait_left > 0) begin
               send_wait_left <= send_wait_left - 1;
               req_bus.valid <= 1'b0;
            end else if (pending_edges.size() != 0) begin
               req_bus.valid <= 1'b1;
               req_bus.rising_edge <= pending_edges[0].rising_edge;
               req_bus.width_us <= pending_edges[0].width_us;
               void'(pending_edges.pop_front());
               send_wait_left <= draw_wait(sender_calm);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         rsp_wait_left <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_frames.size() == 0) begin
               $error("unexpected frame item, frame_code %h", rsp_bus.frame_code);
               error_count++;
            end else begin
               oldest_frame = expected_frames.pop_front();
               if (rsp_bus.frame_code !== oldest_frame.frame_code) begin
                  $error("frame_code: expected %h, actual %h",
                         oldest_frame.frame_code, rsp_bus.frame_code);
                  error_count++;
               end
               if (rsp_bus.id_match !== oldest_frame.id_match) begin
                  $error("id_match: expected %b, actual %b",
                         oldest_frame.id_match, rsp_bus.id_match);
                  error_count++;
               end
               if (rsp_bus.pair_candidate !== oldest_frame.pair_candidate) begin
                  $error("pair_candidate: expected %b, actual %b",
                         oldest_frame.pair_candidate, rsp_bus.pair_candidate);
                  error_count++;
               end
               frames_checked++;
            end
         end
         if (hold_off_request) begin
            hold_off_request <= 1'b0;
            rsp_wait_left <= HOLD_OFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_draw = draw_wait(receiver_calm);
            rsp_wait_left <= rsp_draw;
            rsp_bus.ready <= (rsp_draw == 0);
         end else if (rsp_wait_left > 0) begin
            rsp_wait_left <= rsp_wait_left - 1;
            rsp_bus.ready <= (rsp_wait_left == 1);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic void push_edge(input logic rising, input logic [WIDTH_W-1:0] width);
      edge_item_type item;
      item.rising_edge = rising;
      item.width_us = width;
      pending_edges.push_back(item);
      edges_pushed++;
   endfunction

   // Picks a width strictly inside the window, often right next to its bounds.
   // An empty or inverted window yields any width at all.
   function automatic logic [WIDTH_W-1:0] pick_between(input int lo, input int hi);
      if (hi - lo < 2) return WIDTH_W'($urandom_range(0, 65535));
      case ($urandom_range(0, 5))
         0: return WIDTH_W'(lo + 1);
         1: return WIDTH_W'(hi - 1);
         default: return WIDTH_W'($urandom_range(lo + 1, hi - 1));
      endcase
   endfunction

   function automatic void push_frame(input logic [CODE_W-1:0] code, input int bit_total,
                                      input bit noisy);
      logic [31:0] pattern;
      pattern = ($urandom() << CODE_W) | 32'(code);
      push_edge(1'b1, pick_between(rx_cfg.sync_floor_us, rx_cfg.sync_ceil_us));
      for (int i = FRAME_BITS - 1; i >= FRAME_BITS - bit_total; i--) begin
         if (noisy && $urandom_range(0, 7) == 0)
            push_edge(1'($urandom_range(0, 1)), WIDTH_W'($urandom_range(0, 65535)));
         if (pattern[i]) push_edge(1'b0, pick_between(rx_cfg.one_min_us, rx_cfg.one_max_us));
         else push_edge(1'b0, pick_between(rx_cfg.zero_min_us, rx_cfg.zero_max_us));
         if ($urandom_range(0, 2) != 0) push_edge(1'b1, WIDTH_W'($urandom_range(150, 1500)));
      end
      if (bit_total == FRAME_BITS) frames_pushed++;
   endfunction

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int unsigned value);
      logic [CSR_DATA_W-1:0] data;
      data = value[CSR_DATA_W-1:0];
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      case (index)
         REG_SYNC_MIN: rx_cfg.sync_floor_us = data[WIDTH_W-1:0];
         REG_SYNC_MAX: rx_cfg.sync_ceil_us = data[WIDTH_W-1:0];
         REG_ZERO_MIN: rx_cfg.zero_min_us = data[WIDTH_W-1:0];
         REG_ZERO_MAX: rx_cfg.zero_max_us = data[WIDTH_W-1:0];
         REG_ONE_MIN: rx_cfg.one_min_us = data[WIDTH_W-1:0];
         REG_ONE_MAX: rx_cfg.one_max_us = data[WIDTH_W-1:0];
         REG_PAIRED_ID: rx_cfg.paired_id = data[CODE_W-1:0];
         REG_PAIRED_MODE: rx_cfg.paired_mode = data[0];
         default: ;
      endcase
   endtask

   // Unused upper data bits carry random junk that the block must drop.
   task automatic apply_config(input int sync_lo, input int sync_hi, input int zero_lo,
                               input int zero_hi, input int one_lo, input int one_hi,
                               input int unsigned id, input bit mode);
      write_reg(REG_SYNC_MIN, ($urandom() << WIDTH_W) | 16'(sync_lo));
      write_reg(REG_SYNC_MAX, ($urandom() << WIDTH_W) | 16'(sync_hi));
      write_reg(REG_ZERO_MIN, ($urandom() << WIDTH_W) | 16'(zero_lo));
      write_reg(REG_ZERO_MAX, ($urandom() << WIDTH_W) | 16'(zero_hi));
      write_reg(REG_ONE_MIN, ($urandom() << WIDTH_W) | 16'(one_lo));
      write_reg(REG_ONE_MAX, ($urandom() << WIDTH_W) | 16'(one_hi));
      write_reg(REG_PAIRED_ID, id);
      write_reg(REG_PAIRED_MODE, ($urandom() << 1) | mode);
      @(posedge clock);
      csr_we <= 1'b0;
      setting_count++;
   endtask

   task automatic random_config();
      int sync_lo, zero_lo, zero_hi, one_lo, swap;
      sync_lo = $urandom_range(0, 9000);
      zero_lo = $urandom_range(0, 400);
      zero_hi = zero_lo + $urandom_range(0, 600);
      one_lo = zero_hi - $urandom_range(0, 150);
      if (one_lo < 0) one_lo = 0;
      if ($urandom_range(0, 7) == 0) begin
         swap = zero_lo;
         zero_lo = zero_hi;
         zero_hi = swap;
      end
      apply_config(sync_lo, sync_lo + $urandom_range(0, 8000), zero_lo, zero_hi,
                   one_lo, one_lo + $urandom_range(0, 900),
                   $urandom_range(0, 24'hFFFFFF), 1'($urandom_range(0, 1)));
   endtask

   // Waits until every edge is taken and every frame has come back or the wait limit
   // runs out, then lets the pipeline settle so that a configuration write finds the block idle.
   task automatic drain();
      int waited;
      waited = 0;
      while (pending_edges.size() != 0 || req_bus.valid) @(posedge clock);
      while (expected_frames.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_frames.size() != 0) begin
         $error("%0d expected frame items never arrived", expected_frames.size());
         error_count += expected_frames.size();
         expected_frames.delete();
      end
   endtask

   initial begin
      logic [31:0] directed_bits;
      logic [CODE_W-1:0] code;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_bus.valid = 1'b0;
      req_bus.rising_edge = 1'b0;
      req_bus.width_us = '0;
      rsp_bus.ready = 1'b0;
      sender_calm = 1'b0;
      receiver_calm = 1'b0;
      hold_off_request = 1'b0;
      rx_cfg.sync_floor_us = SYNC_MIN_RESET;
      rx_cfg.sync_ceil_us = SYNC_MAX_RESET;
      rx_cfg.zero_min_us = ZERO_MIN_RESET;
      rx_cfg.zero_max_us = ZERO_MAX_RESET;
      rx_cfg.one_min_us = ONE_MIN_RESET;
      rx_cfg.one_max_us = ONE_MAX_RESET;
      rx_cfg.paired_id = PAIRED_ID_RESET;
      rx_cfg.paired_mode = 1'b0;
      rx_armed = 1'b0;
      rx_shift = '0;
      rx_count = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Default windows: edges at and around the window bounds, where only 5501 arms,
      // then one frame whose bit widths sit just inside the bit window bounds.
      push_edge(1'b0, 16'd300);
      push_edge(1'b1, 16'd0);
      push_edge(1'b1, 16'd5500);
      push_edge(1'b1, 16'd10000);
      push_edge(1'b1, 16'd5501);
      push_edge(1'b1, 16'hFFFF);
      push_edge(1'b1, 16'd9999);
      push_edge(1'b0, 16'd0);
      push_edge(1'b0, 16'hFFFF);
      push_edge(1'b0, 16'd100);
      push_edge(1'b0, 16'd400);
      push_edge(1'b0, 16'd900);
      directed_bits = 32'h01A5C3E9;
      for (int i = FRAME_BITS - 1; i >= 0; i--) begin
         if (directed_bits[i]) push_edge(1'b0, (i % 2) ? 16'd401 : 16'd899);
         else push_edge(1'b0, (i % 2) ? 16'd101 : 16'd399);
      end
      drain();

      apply_config(5500, 10000, 100, 400, 400, 900, 24'h5A5A5A, 1'b1);
      push_frame(24'h5A5A5A, FRAME_BITS, 1'b0);
      push_frame(24'h5A5A5B, FRAME_BITS, 1'b0);
      drain();

      apply_config(5500, 10000, 100, 400, 400, 900, 24'h000000, 1'b1);
      push_frame(24'h000000, FRAME_BITS, 1'b0);
      push_frame(24'hFFFFFF, FRAME_BITS, 1'b0);
      drain();

      // Overlapping bit windows, the zero window wins.
      apply_config(0, 65535, 100, 700, 300, 900, 24'hFFFFFF, 1'b0);
      push_frame(CODE_W'($urandom_range(0, 24'hFFFFFF)), FRAME_BITS, 1'b0);
      push_frame(CODE_W'($urandom_range(0, 24'hFFFFFF)), FRAME_BITS, 1'b1);
      drain();

      apply_config(0, 65535, 65535, 0, 0, 65535, 24'hFFFFFF, 1'b1);
      push_frame(24'hFFFFFF, FRAME_BITS, 1'b0);
      push_frame(24'hFFFFFF, FRAME_BITS, 1'b1);
      drain();

      apply_config(65535, 0, 0, 65535, 65535, 65535, 24'h800001, 1'b1);
      push_frame(CODE_W'($urandom_range(0, 24'hFFFFFF)), FRAME_BITS, 1'b1);
      drain();

      // The receiver holds off while clean frames arrive back to back, so the
      // block fills up and stalls its input.
      apply_config(5500, 10000, 100, 400, 400, 900, 24'h123456, 1'b0);
      sender_calm <= 1'b1;
      receiver_calm <= 1'b1;
      hold_off_request <= 1'b1;
      repeat (4) push_frame(CODE_W'($urandom_range(0, 24'hFFFFFF)), FRAME_BITS, 1'b0);
      drain();
      sender_calm <= 1'b0;
      receiver_calm <= 1'b0;

      while (edges_pushed < ITEM_TARGET || frames_pushed < FRAME_TARGET) begin
         random_config();
         sender_calm <= ($urandom_range(0, 3) == 0);
         receiver_calm <= ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(4, 8)) begin
            if (rx_cfg.paired_mode && $urandom_range(0, 2) == 0) code = rx_cfg.paired_id;
            else code = CODE_W'($urandom_range(0, 24'hFFFFFF));
            case ($urandom_range(0, 9))
               0: repeat ($urandom_range(1, 6))
                     push_edge(1'($urandom_range(0, 1)), WIDTH_W'($urandom_range(0, 65535)));
               1: push_frame(code, $urandom_range(0, FRAME_BITS - 1), 1'b1);
               2: push_frame(code, FRAME_BITS, 1'b1);
               default: push_frame(code, FRAME_BITS, 1'b0);
            endcase
         end
         drain();
      end

      $display("Run covered %0d accepted edge items and %0d checked frames over %0d settings.",
               edges_accepted, frames_checked, setting_count);
      if (error_count == 0) begin
         $display("rf_pulse_width_code_receiver_test: clean");
      end else begin
         $display("rf_pulse_width_code_receiver_test: errors");
      end
      $finish;
   end

endmodule
